/* hdl/cpc_pkg.sv */
`default_nettype none

package cpc_pkg;

    // Default polygon table depth.
    localparam int MAX_VERTICES_DEF = 64;

    // Fixed field widths.
    localparam int COORD_W = 16;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 7;

    // Edge arithmetic widths: coordinate differences, products, cross product.
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    // Request commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_ORIENTATION  = 1'b1;

    // Configuration reset values.
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 7'd36;
    localparam logic               ORIENT_RESET = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vertex_t;

    // Control that travels with an edge through the edge unit.
    typedef struct packed {
        logic valid;
        logic last;
    } edge_ctl_t;

    // Operands of one edge test: edge start, edge end and query point.
    typedef struct packed {
        vertex_t vi;
        vertex_t vj;
        vertex_t pt;
    } edge_req_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic viol;
    } edge_res_t;

endpackage

`default_nettype wire

/* hdl/cpc_channels.sv */
`default_nettype none

// Input request channel: vertex loads and point queries.
interface cpc_in_if import cpc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [INDEX_W-1:0]        vertex_index;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    modport source (
        output valid, command, vertex_index, vertex_x, vertex_y, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, command, vertex_index, vertex_x, vertex_y, point_x, point_y,
        output ready
    );
endinterface

// Result channel: one hit flag per query.
interface cpc_out_if import cpc_pkg::*; ();
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );
    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/cpc_vertex_ram.sv */
`default_nettype none

module cpc_vertex_ram import cpc_pkg::*; #(
    parameter int DEPTH = MAX_VERTICES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire vertex_t       wdata,
    input  wire logic [AW-1:0] raddr,
    output vertex_t            rdata
);

    vertex_t mem [DEPTH];
    vertex_t rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/cpc_edge_unit.sv */
`default_nettype none

module cpc_edge_unit import cpc_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire edge_ctl_t ctl,
    input  wire edge_req_t req,
    input  wire logic      orientation,
    output edge_res_t      res
);

    edge_ctl_t                s1_ctl_reg;
    edge_ctl_t                s2_ctl_reg;
    edge_res_t                res_reg;
    edge_res_t                res_next;
    logic signed [DIFF_W-1:0] dpy_reg, dxe_reg, dpx_reg, dye_reg;
    logic signed [DIFF_W-1:0] dpy_next, dxe_next, dpx_next, dye_next;
    logic signed [PROD_W-1:0] p1_reg, p2_reg;
    logic signed [PROD_W-1:0] p1_next, p2_next;
    logic signed [CROSS_W-1:0] cross_next;

    // Stage one: the four coordinate differences.
    always_comb
    begin
        dpy_next = DIFF_W'(req.pt.y) - DIFF_W'(req.vi.y);
        dxe_next = DIFF_W'(req.vj.x) - DIFF_W'(req.vi.x);
        dpx_next = DIFF_W'(req.pt.x) - DIFF_W'(req.vi.x);
        dye_next = DIFF_W'(req.vj.y) - DIFF_W'(req.vi.y);
    end

    // Stage two: the two products.
    always_comb
    begin
        p1_next = PROD_W'(dpy_reg) * PROD_W'(dxe_reg);
        p2_next = PROD_W'(dpx_reg) * PROD_W'(dye_reg);
    end

    // Stage three: cross product and the side test for the chosen orientation.
    always_comb
    begin
        cross_next     = CROSS_W'(p1_reg) - CROSS_W'(p2_reg);
        res_next.valid = s2_ctl_reg.valid;
        res_next.last  = s2_ctl_reg.last;
        res_next.viol  = orientation ? (cross_next < 1) : (cross_next > -1);
    end

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            res_reg    <= '0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
            res_reg    <= res_next;
        end
    end

    // Pipeline data.
    always_ff @(posedge clk)
    begin
        dpy_reg <= dpy_next;
        dxe_reg <= dxe_next;
        dpx_reg <= dpx_next;
        dye_reg <= dye_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* hdl/convex_polygon_containment.sv */
`default_nettype none

// Load request: gives no result.
// Query request: hit is the OR of the side-test violations of the polygon's edges, where n is
// vertex_count saturated to MAX_VERTICES (with n zero the query goes straight to done); the input is not
// ready meanwhile, and a finished query waits in the done state while a result is held.
// Throughput: one load per cycle while idle, one edge per cycle while a query runs.
// Reset sets vertex_count to 36 and orientation to 1; the vertex tables are not cleared.
module convex_polygon_containment import cpc_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    cpc_in_if.sink           in_ch,
    cpc_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = ($clog2(MAX_VERTICES + 1) > COUNT_W) ?
                        $clog2(MAX_VERTICES + 1) : COUNT_W;
    localparam int IW = ($clog2(MAX_VERTICES + 1) > INDEX_W) ?
                        $clog2(MAX_VERTICES + 1) : INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               orient_reg, orient_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [NW-1:0]      issue_cnt_reg, issue_cnt_next;
    logic               arr_valid_reg, arr_valid_next;
    logic               arr_first_reg, arr_first_next;
    logic               arr_last_reg, arr_last_next;
    logic               close_pend_reg, close_pend_next;
    logic               hit_acc_reg, hit_acc_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    vertex_t            pt_reg, pt_next;
    vertex_t            first_reg, first_next;
    vertex_t            prev_reg, prev_next;

    logic               in_accept;
    logic               out_take;
    logic               issue_en;
    logic [NW-1:0]      n_sat;
    logic               mem_we;
    vertex_t            mem_wdata;
    vertex_t            rd_data;
    edge_ctl_t          edge_ctl;
    edge_req_t          edge_req;
    edge_res_t          edge_res;

    // Handshakes.
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_accept    = in_ch.valid && in_ch.ready;
    assign out_take     = out_valid_reg && out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.hit   = out_hit_reg;

    // Vertex count in use, saturated to the table depth.
    assign n_sat = (NW'(count_reg) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                        : NW'(count_reg);

    // Loads beyond the table depth are dropped.
    assign mem_we      = in_accept && (in_ch.command == CMD_LOAD) &&
                         (IW'(in_ch.vertex_index) < IW'(MAX_VERTICES));
    assign mem_wdata.x = in_ch.vertex_x;
    assign mem_wdata.y = in_ch.vertex_y;

    // Vertices are read in order, one address per cycle.
    assign issue_en = (state_reg == S_RUN) && (issue_cnt_reg < n_reg);

    cpc_vertex_ram #(
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(in_ch.vertex_index)),
        .wdata (mem_wdata),
        .raddr (issue_cnt_reg[AW-1:0]),
        .rdata (rd_data)
    );

    // An edge enters on every vertex after the first, then the closing edge.
    always_comb
    begin
        edge_ctl.valid = (state_reg == S_RUN) &&
                         ((arr_valid_reg && !arr_first_reg) || close_pend_reg);
        edge_ctl.last  = close_pend_reg;
        edge_req.vi    = prev_reg;
        edge_req.vj    = close_pend_reg ? first_reg : rd_data;
        edge_req.pt    = pt_reg;
    end

    cpc_edge_unit u_edge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (edge_ctl),
        .req         (edge_req),
        .orientation (orient_reg),
        .res         (edge_res)
    );

    // Sequencer, configuration and result register.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        orient_next     = orient_reg;
        n_next          = n_reg;
        issue_cnt_next  = issue_cnt_reg;
        arr_valid_next  = issue_en;
        arr_first_next  = (issue_cnt_reg == '0);
        arr_last_next   = (issue_cnt_reg == n_reg - NW'(1));
        close_pend_next = 1'b0;
        hit_acc_next    = hit_acc_reg;
        out_valid_next  = out_valid_reg && !out_take;
        out_hit_next    = out_hit_reg;
        pt_next         = pt_reg;
        first_next      = first_reg;
        prev_next       = prev_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT: count_next  = cfg_data;
                CFG_ORIENTATION:  orient_next = cfg_data[0];
                default:          count_next  = count_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_ch.command == CMD_QUERY))
                begin
                    n_next         = n_sat;
                    issue_cnt_next = '0;
                    hit_acc_next   = 1'b0;
                    pt_next.x      = in_ch.point_x;
                    pt_next.y      = in_ch.point_y;
                    state_next     = (n_sat == '0) ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                if (issue_en)
                begin
                    issue_cnt_next = issue_cnt_reg + NW'(1);
                end
                if (arr_valid_reg)
                begin
                    prev_next = rd_data;
                    if (arr_first_reg)
                    begin
                        first_next = rd_data;
                    end
                    close_pend_next = arr_last_reg;
                end
                if (edge_res.valid)
                begin
                    hit_acc_next = hit_acc_reg | edge_res.viol;
                    if (edge_res.last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= COUNT_RESET;
            orient_reg     <= ORIENT_RESET;
            n_reg          <= '0;
            issue_cnt_reg  <= '0;
            arr_valid_reg  <= 1'b0;
            arr_first_reg  <= 1'b0;
            arr_last_reg   <= 1'b0;
            close_pend_reg <= 1'b0;
            hit_acc_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            orient_reg     <= orient_next;
            n_reg          <= n_next;
            issue_cnt_reg  <= issue_cnt_next;
            arr_valid_reg  <= arr_valid_next;
            arr_first_reg  <= arr_first_next;
            arr_last_reg   <= arr_last_next;
            close_pend_reg <= close_pend_next;
            hit_acc_reg    <= hit_acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_hit_reg <= out_hit_next;
        pt_reg      <= pt_next;
        first_reg   <= first_next;
        prev_reg    <= prev_next;
    end

    // An edge result only comes back while a query runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_res.valid |-> (state_reg == S_RUN))
        else $error("edge result outside a running query");

    // The read counter never passes the vertex count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (issue_cnt_reg <= n_reg))
        else $error("vertex read counter overran the count");

    // An accepted query always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_ch.command == CMD_QUERY)) |=> (state_reg != S_IDLE))
        else $error("query accepted but sequencer stayed idle");

    // A result appears only from the done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the done state");

    // The closing edge and a vertex arrival never coincide.
    assert property (@(posedge clk) disable iff (!rst_n)
        close_pend_reg |-> !arr_valid_reg)
        else $error("closing edge collided with a vertex read");

endmodule

`default_nettype wire
